/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file of the sine/cosine core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked at every rising edge of clk while rst_n is high.
`define SCP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sine/cosine core assertion failed");

// Checked at every rising edge of clk, reset included.
`define SCP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sine/cosine core assertion failed");

`else

`define SCP_ASSERT(lbl, clk, rst_n, prop)
`define SCP_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* rtl/scp_pkg.sv */
// Shared constants, types and rounding functions of the sine/cosine core.
package scp_pkg;

  localparam int ANGLE_WIDTH_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  localparam int OUT_W  = 18;   // Q1.16 result width
  localparam int POLY_W = 32;   // Q.30 polynomial datapath width
  localparam int T40_W  = 43;   // reduced angle in Q.40
  localparam int HP_W   = 41;   // width of the pi/2 constant

  localparam logic [31:0]     TWO_OVER_PI_Q32 = 32'hA2F9836E;
  localparam logic [HP_W-1:0] HALF_PI_Q40     = 41'h1921FB54443;

  localparam logic signed [POLY_W-1:0] ONE_Q30    = 32'sd1073741824;
  localparam logic signed [POLY_W-1:0] C_INV6     = 32'sd178956971;
  localparam logic signed [POLY_W-1:0] C_INV120   = 32'sd8947849;
  localparam logic signed [POLY_W-1:0] C_INV5040  = 32'sd213044;
  localparam logic signed [POLY_W-1:0] C_HALF     = 32'sd536870912;
  localparam logic signed [POLY_W-1:0] C_INV24    = 32'sd44739243;
  localparam logic signed [POLY_W-1:0] C_INV720   = 32'sd1491308;
  localparam logic signed [POLY_W-1:0] C_INV40320 = 32'sd26631;

  localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sd65536;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sd65536;

  localparam logic signed [2*POLY_W-1:0] HALF_Q30 = 64'sd536870912;
  localparam logic signed [T40_W-1:0]    HALF_T40 = 43'sd512;
  localparam logic signed [POLY_W-1:0]   HALF_Q16 = 32'sd8192;

  // Reduced angle handed from the range reduction to the polynomial pipeline.
  typedef struct packed {
    logic                     vld;
    logic [1:0]               quad;
    logic signed [POLY_W-1:0] t;
  } red_t;

  // Polynomial results handed to the output stage.
  typedef struct packed {
    logic                     vld;
    logic [1:0]               quad;
    logic signed [POLY_W-1:0] s;
    logic signed [POLY_W-1:0] c;
  } hor_t;

  // Q.60 product back to Q.30, halves away from zero.
  function automatic logic signed [POLY_W-1:0] rnd_q30(
    input logic signed [2*POLY_W-1:0] v
  );
    logic signed [2*POLY_W-1:0] r;
    r = v + HALF_Q30 - {{(2*POLY_W-1){1'b0}}, v[2*POLY_W-1]};
    return POLY_W'(r >>> 30);
  endfunction

  // Q.40 angle to Q.30, halves away from zero.
  function automatic logic signed [POLY_W-1:0] rnd_t40(
    input logic signed [T40_W-1:0] v
  );
    logic signed [T40_W-1:0] r;
    r = v + HALF_T40 - {{(T40_W-1){1'b0}}, v[T40_W-1]};
    return POLY_W'(r >>> 10);
  endfunction

  // Q.30 to Q.16, halves away from zero.
  function automatic logic signed [POLY_W-1:0] rnd_q16(
    input logic signed [POLY_W-1:0] v
  );
    logic signed [POLY_W-1:0] r;
    r = v + HALF_Q16 - {{(POLY_W-1){1'b0}}, v[POLY_W-1]};
    return r >>> 14;
  endfunction

endpackage

/* rtl/scp_reduce.sv */
// Quadrant range reduction: five pipeline stages from angle to reduced Q.30 angle.
module scp_reduce #(
  parameter int ANGLE_WIDTH = scp_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS   = scp_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output scp_pkg::red_t                 red
);

  localparam int NW = ANGLE_WIDTH - FRAC_BITS + 1;
  localparam int PW = ANGLE_WIDTH + 32;
  localparam int DW = ANGLE_WIDTH - FRAC_BITS + 44;
  localparam logic [PW:0] N_HALF = (PW + 1)'(1) << (31 + FRAC_BITS);

  logic [ANGLE_WIDTH-1:0] mag;
  logic [PW:0]            n_sum;
  logic [NW-1:0]          nmag;
  logic signed [DW-1:0]   a40;
  logic signed [DW-1:0]   np_ext;
  logic signed [DW-1:0]   t40_full;

  // Stage A: magnitude times 2/pi.
  logic                          va_r, nega_r;
  logic signed [ANGLE_WIDTH-1:0] anga_r;
  logic [PW-1:0]                 pa_r;
  // Stage B: rounded quadrant count.
  logic                          vb_r, negb_r;
  logic signed [ANGLE_WIDTH-1:0] angb_r;
  logic [NW-1:0]                 nmagb_r;
  logic [1:0]                    qb_r;
  // Stage C: n times pi/2.
  logic                          vc_r, negc_r;
  logic signed [ANGLE_WIDTH-1:0] angc_r;
  logic [1:0]                    qc_r;
  logic [NW+scp_pkg::HP_W-1:0]   npc_r;
  // Stage D: reduced angle in Q.40.
  logic                          vd_r;
  logic [1:0]                    qd_r;
  logic signed [scp_pkg::T40_W-1:0] t40d_r;
  // Stage E: reduced angle in Q.30.
  logic                          ve_r;
  logic [1:0]                    qe_r;
  logic signed [scp_pkg::POLY_W-1:0] te_r;

  assign mag      = angle[ANGLE_WIDTH-1] ? (~angle + 1'b1) : angle;
  assign n_sum    = (PW + 1)'(pa_r) + N_HALF;
  assign nmag     = n_sum[PW:32+FRAC_BITS];
  assign a40      = DW'(angc_r) <<< (40 - FRAC_BITS);
  assign np_ext   = signed'(DW'(npc_r));
  assign t40_full = negc_r ? (a40 + np_ext) : (a40 - np_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nega_r  <= angle[ANGLE_WIDTH-1];
      anga_r  <= angle;
      pa_r    <= PW'(mag) * PW'(scp_pkg::TWO_OVER_PI_Q32);

      negb_r  <= nega_r;
      angb_r  <= anga_r;
      nmagb_r <= nmag;
      qb_r    <= nega_r ? (2'b00 - nmag[1:0]) : nmag[1:0];

      negc_r  <= negb_r;
      angc_r  <= angb_r;
      qc_r    <= qb_r;
      npc_r   <= (NW + scp_pkg::HP_W)'(nmagb_r) *
                 (NW + scp_pkg::HP_W)'(scp_pkg::HALF_PI_Q40);

      qd_r    <= qc_r;
      t40d_r  <= t40_full[scp_pkg::T40_W-1:0];

      qe_r    <= qd_r;
      te_r    <= scp_pkg::rnd_t40(t40d_r);
    end
  end

  assign red.vld  = ve_r;
  assign red.quad = qe_r;
  assign red.t    = te_r;

endmodule

/* rtl/scp_horner.sv */
// Horner evaluation of sine and cosine polynomials: ten pipeline stages.
module scp_horner (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  scp_pkg::red_t red,
  output scp_pkg::hor_t hor
);

  localparam int PWD = 2 * scp_pkg::POLY_W;

  logic                             vld_r  [10];
  logic [1:0]                       quad_r [10];
  logic signed [scp_pkg::POLY_W-1:0] t_r   [8];
  logic signed [scp_pkg::POLY_W-1:0] t2_r  [1:7];

  logic signed [PWD-1:0]            sq_r;
  logic signed [PWD-1:0]            ms2_r, mc2_r, ms4_r, mc4_r, ms6_r, mc6_r, ms8_r, mc8_r;
  logic signed [scp_pkg::POLY_W-1:0] as3_r, ac3_r, as5_r, ac5_r, as7_r, ac7_r;
  logic signed [scp_pkg::POLY_W-1:0] s9_r, c9_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 10; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= red.vld;
      for (int i = 1; i < 10; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad_r[0] <= red.quad;
      for (int i = 1; i < 10; i++) begin
        quad_r[i] <= quad_r[i-1];
      end
      t_r[0] <= red.t;
      for (int i = 1; i < 8; i++) begin
        t_r[i] <= t_r[i-1];
      end
      for (int i = 2; i < 8; i++) begin
        t2_r[i] <= t2_r[i-1];
      end

      sq_r    <= PWD'(red.t) * PWD'(red.t);
      t2_r[1] <= scp_pkg::rnd_q30(sq_r);

      ms2_r <= PWD'(t2_r[1]) * PWD'(scp_pkg::C_INV5040);
      mc2_r <= PWD'(t2_r[1]) * PWD'(scp_pkg::C_INV40320);
      as3_r <= scp_pkg::C_INV120 - scp_pkg::rnd_q30(ms2_r);
      ac3_r <= scp_pkg::C_INV720 - scp_pkg::rnd_q30(mc2_r);

      ms4_r <= PWD'(t2_r[3]) * PWD'(as3_r);
      mc4_r <= PWD'(t2_r[3]) * PWD'(ac3_r);
      as5_r <= scp_pkg::C_INV6 - scp_pkg::rnd_q30(ms4_r);
      ac5_r <= scp_pkg::C_INV24 - scp_pkg::rnd_q30(mc4_r);

      ms6_r <= PWD'(t2_r[5]) * PWD'(as5_r);
      mc6_r <= PWD'(t2_r[5]) * PWD'(ac5_r);
      as7_r <= scp_pkg::ONE_Q30 - scp_pkg::rnd_q30(ms6_r);
      ac7_r <= scp_pkg::C_HALF - scp_pkg::rnd_q30(mc6_r);

      // Sine closes with a multiply by t, cosine with one more t^2 step.
      ms8_r <= PWD'(t_r[7]) * PWD'(as7_r);
      mc8_r <= PWD'(t2_r[7]) * PWD'(ac7_r);
      s9_r  <= scp_pkg::rnd_q30(ms8_r);
      c9_r  <= scp_pkg::ONE_Q30 - scp_pkg::rnd_q30(mc8_r);
    end
  end

  assign hor.vld  = vld_r[9];
  assign hor.quad = quad_r[9];
  assign hor.s    = s9_r;
  assign hor.c    = c9_r;

endmodule

/* rtl/sine_cosine_polynomial_core.sv */
// Top level of the pipelined fixed-point sine/cosine core.
//
//  Channel  Ports                          Dir  Payload
//  input    in_valid, in_ready, in_angle   in   angle, signed Q7.16 radians
//  result   out_valid, out_ready,          out  sine, cosine, signed Q1.16
//           out_sine, out_cosine
//
// One item can enter every cycle while in_ready is high. Its path to the output register runs
// through five range-reduction stages, ten Horner stages and the output register itself.
// A single pipeline enable moves every stage whenever the output register is empty or
// being drained, so a stall on out_ready freezes all stages and nothing is lost or repeated.
// in_ready is that same enable, so it stays high while the output register is empty.
// Reset (synchronous, active low) clears the valid bits of all stages.
`include "assert_macros.svh"

module sine_cosine_polynomial_core #(
  parameter int ANGLE_WIDTH = scp_pkg::ANGLE_WIDTH_DEF,
  parameter int FRAC_BITS   = scp_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ANGLE_WIDTH-1:0]       in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [scp_pkg::OUT_W-1:0]    out_sine,
  output logic signed [scp_pkg::OUT_W-1:0]    out_cosine
);

  logic          en;
  scp_pkg::red_t red;
  scp_pkg::hor_t hor;

  logic signed [scp_pkg::POLY_W-1:0] sine_q30, cosine_q30;
  logic signed [scp_pkg::POLY_W-1:0] sine_q16, cosine_q16;

  logic                               out_valid_r;
  logic signed [scp_pkg::OUT_W-1:0]   sine_r, cosine_r;

  // The whole pipeline moves as one; bubbles are filled while the output waits
  // only if the output register is empty.
  assign en       = out_ready || !out_valid_r;
  assign in_ready = en;

  scp_reduce #(
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_reduce (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_valid),
    .angle  (in_angle),
    .red    (red)
  );

  scp_horner u_horner (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .red   (red),
    .hor   (hor)
  );

  // Quadrant map: each quarter turn swaps the pair and negates one member.
  always_comb begin
    case (hor.quad)
      2'd0: begin
        sine_q30   = hor.s;
        cosine_q30 = hor.c;
      end
      2'd1: begin
        sine_q30   = hor.c;
        cosine_q30 = -hor.s;
      end
      2'd2: begin
        sine_q30   = -hor.s;
        cosine_q30 = -hor.c;
      end
      default: begin
        sine_q30   = -hor.c;
        cosine_q30 = hor.s;
      end
    endcase
  end

  assign sine_q16   = scp_pkg::rnd_q16(sine_q30);
  assign cosine_q16 = scp_pkg::rnd_q16(cosine_q30);

  // Clamp to plus or minus one so that a polynomial overshoot never leaks out.
  function automatic logic signed [scp_pkg::OUT_W-1:0] sat_one(
    input logic signed [scp_pkg::POLY_W-1:0] v
  );
    if (v > scp_pkg::POLY_W'(scp_pkg::OUT_MAX)) begin
      return scp_pkg::OUT_MAX;
    end else if (v < scp_pkg::POLY_W'(scp_pkg::OUT_MIN)) begin
      return scp_pkg::OUT_MIN;
    end
    return scp_pkg::OUT_W'(v);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= hor.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine_r   <= sat_one(sine_q16);
      cosine_r <= sat_one(cosine_q16);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sine   = sine_r;
  assign out_cosine = cosine_r;

  // Results never leave the range of plus or minus one.
  `SCP_ASSERT(a_sine_range, clk, rst_n, out_valid |-> (out_sine <= scp_pkg::OUT_MAX && out_sine >= scp_pkg::OUT_MIN))
  `SCP_ASSERT(a_cosine_range, clk, rst_n, out_valid |-> (out_cosine <= scp_pkg::OUT_MAX && out_cosine >= scp_pkg::OUT_MIN))
  // A stall must freeze the polynomial results feeding the output stage.
  `SCP_ASSERT(a_stall_freeze, clk, rst_n, !en |=> ($stable(hor.s) && $stable(hor.c) && $stable(hor.vld)))
  // Reset empties the output register.
  `SCP_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule
